// File: hw/rtl/ioa_pkg.sv
// ioa_pkg: shared types, opcodes, status codes and widths for the integer ALU.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none
package ioa_pkg;
  localparam int DataWidth  = 32;
  localparam int ShiftWidth = $clog2(DataWidth);
  // one divider cell per quotient bit, plus input, entry and exit stages
  localparam int NumCells   = DataWidth;
  localparam int Latency    = NumCells + 3;

  typedef logic [DataWidth-1:0] word_t;
  typedef logic [4:0]           opcode_t;
  typedef logic [1:0]           status_t;

  localparam opcode_t OpInc  = 5'd0;
  localparam opcode_t OpDec  = 5'd1;
  localparam opcode_t OpLnot = 5'd2;
  localparam opcode_t OpBnot = 5'd3;
  localparam opcode_t OpNeg  = 5'd4;
  localparam opcode_t OpAdd  = 5'd5;
  localparam opcode_t OpSub  = 5'd6;
  localparam opcode_t OpMul  = 5'd7;
  localparam opcode_t OpDiv  = 5'd8;
  localparam opcode_t OpMod  = 5'd9;
  localparam opcode_t OpAnd  = 5'd10;
  localparam opcode_t OpOr   = 5'd11;
  localparam opcode_t OpXor  = 5'd12;
  localparam opcode_t OpGt   = 5'd13;
  localparam opcode_t OpLt   = 5'd14;
  localparam opcode_t OpShl  = 5'd15;
  localparam opcode_t OpShr  = 5'd16;
  localparam opcode_t OpLand = 5'd17;
  localparam opcode_t OpLor  = 5'd18;
  localparam opcode_t OpEq   = 5'd19;

  localparam status_t StOk     = 2'd0;
  localparam status_t StDivZero = 2'd1;
  localparam status_t StUnsup  = 2'd2;

  // payload carried down the cell chain
  typedef struct packed {
    logic    vld;
    word_t   rem;      // partial remainder
    word_t   quo;      // dividend shifting out / quotient shifting in
    word_t   dvs;      // divisor magnitude
    logic    neg_q;    // negate quotient at exit
    logic    neg_r;    // negate remainder at exit
    logic    is_div;   // quotient path
    logic    is_mod;   // remainder path
    word_t   res;      // result of non-divide ops
    status_t st;
  } cell_t;
endpackage
`default_nettype wire

// File: hw/rtl/ioa_cell.sv
// ioa_cell: one restoring-division step plus a register; passes the item to the next cell.
// Depends on ioa_pkg.
`default_nettype none
module ioa_cell
  import ioa_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   adv,
  input  cell_t d_in,
  output cell_t d_out
);
  cell_t q_r, q_nxt;
  logic [DataWidth:0] shl_rem, diff;

  // shift one dividend bit in, try subtract
  always_comb begin
    shl_rem = {d_in.rem, d_in.quo[DataWidth-1]};
    diff    = shl_rem - {1'b0, d_in.dvs};
    q_nxt   = d_in;
    if (d_in.is_div || d_in.is_mod) begin
      if (!diff[DataWidth]) begin
        q_nxt.rem = diff[DataWidth-1:0];
        q_nxt.quo = {d_in.quo[DataWidth-2:0], 1'b1};
      end else begin
        q_nxt.rem = shl_rem[DataWidth-1:0];
        q_nxt.quo = {d_in.quo[DataWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule
`default_nettype wire

// File: hw/rtl/ioa_front.sv
// ioa_front: decodes the item, evaluates the non-divide ops and sets up the divide.
// Depends on ioa_pkg.
`default_nettype none
module ioa_front
  import ioa_pkg::*;
(
  input  wire     vld,
  input  opcode_t op,
  input  word_t   a,
  input  word_t   b,
  input  word_t   mul_p,
  output cell_t   d_out
);
  logic                  na, nb;
  logic [ShiftWidth-1:0] sh;
  word_t                 r;
  status_t               st;
  logic                  divop;

  always_comb begin
    na    = a[DataWidth-1];
    nb    = b[DataWidth-1];
    sh    = b[ShiftWidth-1:0];
    r     = '0;
    st    = StOk;
    divop = 1'b0;
    case (op)
      OpInc:  r = a + word_t'(1);
      OpDec:  r = a - word_t'(1);
      OpLnot: r = word_t'(a == '0);
      OpBnot: r = ~a;
      OpNeg:  r = '0 - a;
      OpAdd:  r = a + b;
      OpSub:  r = a - b;
      OpMul:  r = mul_p;
      OpDiv, OpMod: begin
        if (b == '0) st = StDivZero;
        else divop = 1'b1;
      end
      OpAnd:  r = a & b;
      OpOr:   r = a | b;
      OpXor:  r = a ^ b;
      OpGt:   r = word_t'($signed(a) > $signed(b));
      OpLt:   r = word_t'($signed(a) < $signed(b));
      OpShl:  r = a << sh;
      OpShr:  r = word_t'($signed(a) >>> sh);
      OpLand: r = word_t'((a != '0) && (b != '0));
      OpLor:  r = word_t'((a != '0) || (b != '0));
      OpEq:   r = word_t'(a == b);
      default: st = StUnsup;
    endcase
    d_out.vld    = vld;
    d_out.rem    = '0;
    d_out.quo    = na ? ('0 - a) : a;
    d_out.dvs    = nb ? ('0 - b) : b;
    d_out.neg_q  = na ^ nb;
    d_out.neg_r  = na;
    d_out.is_div = divop && (op == OpDiv);
    d_out.is_mod = divop && (op == OpMod);
    d_out.res    = r;
    d_out.st     = st;
  end
endmodule
`default_nettype wire

// File: hw/rtl/integer_operator_alu.sv
// integer_operator_alu: 32-bit signed integer ALU, one item per cycle unless the output is held.
// Every opcode, divide or not, passes through every stage from input accept to result valid.
// Throughput: one item per cycle; the input register, the entry register, the chain of
// 32 divider cells (one quotient bit per cell) and the output register set the latency.
// The whole chain stalls together when the output is held.
// Reset (synchronous, rst_n low) clears every stage valid; no other state.
`default_nettype none
module integer_operator_alu
  import ioa_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  input  wire     in_valid,
  output logic    in_ready,
  input  opcode_t in_operation,
  input  word_t   in_left_operand,
  input  word_t   in_right_operand,
  output logic    out_valid,
  input  wire     out_ready,
  output word_t   out_result_value,
  output status_t out_status
);
  cell_t  ent_r, front_d;
  cell_t  chain [NumCells+1];
  logic   adv;
  word_t  mul_a_r, mul_b_r;
  opcode_t op_r;
  logic   vin_r;
  word_t  res_r;
  status_t st_r;
  logic   ov_r;
  word_t  q, rm, fin;

  // whole pipe advances unless the output is full and held
  assign adv      = !ov_r || out_ready;
  assign in_ready = adv;

  // input register; multiply happens in the next stage from registered operands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_r <= 1'b0;
    end else if (adv) begin
      vin_r   <= in_valid;
      op_r    <= in_operation;
      mul_a_r <= in_left_operand;
      mul_b_r <= in_right_operand;
    end
  end

  ioa_front u_front (
    .vld(vin_r), .op(op_r), .a(mul_a_r), .b(mul_b_r),
    .mul_p(word_t'(mul_a_r * mul_b_r)), .d_out(front_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ent_r.vld <= 1'b0;
    else if (adv) ent_r <= front_d;
  end

  assign chain[0] = ent_r;
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    ioa_cell u_cell (.clk(clk), .rst_n(rst_n), .adv(adv),
                     .d_in(chain[i]), .d_out(chain[i+1]));
  end

  // sign fix-up and output register
  always_comb begin
    q   = chain[NumCells].neg_q ? ('0 - chain[NumCells].quo) : chain[NumCells].quo;
    rm  = chain[NumCells].neg_r ? ('0 - chain[NumCells].rem) : chain[NumCells].rem;
    fin = chain[NumCells].is_div ? q : (chain[NumCells].is_mod ? rm : chain[NumCells].res);
    if (chain[NumCells].st != StOk) fin = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r  <= chain[NumCells].vld;
      res_r <= fin;
      st_r  <= chain[NumCells].st;
    end
  end

  assign out_valid        = ov_r;
  assign out_result_value = res_r;
  assign out_status       = st_r;

  // a held result keeps the input side stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("input taken while output held");
  // held result is stable
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_result_value) && $stable(out_status)))
    else $error("held result changed");
  // nonzero status forces zero value
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != StOk) |-> (out_result_value == '0))
    else $error("error status with nonzero value");
endmodule
`default_nettype wire

// File: verif/integer_operator_alu_checker.sv
// integer_operator_alu_checker: watches both channels of the integer ALU, predicts each
// result from the accepted item and compares it with what comes out. Depends on ioa_pkg.
`timescale 1ns / 1ps
module integer_operator_alu_checker
  import ioa_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  input  wire     in_valid,
  input  wire     in_ready,
  input  opcode_t in_operation,
  input  word_t   in_left_operand,
  input  word_t   in_right_operand,
  input  wire     out_valid,
  input  wire     out_ready,
  input  word_t   out_result_value,
  input  status_t out_status,
  output int      fail_count,
  output int      pending_count,
  output int      result_count
);

  typedef struct packed {
    word_t   value;
    status_t st;
  } alu_result_t;

  alu_result_t expected_results[$];

  // Expected result of one operation, two's complement at DataWidth bits.
  function automatic alu_result_t compute_alu(opcode_t op, word_t a, word_t b);
    alu_result_t r;
    logic signed [DataWidth-1:0] sa;
    logic signed [DataWidth-1:0] sb;
    word_t ua;
    word_t ub;
    word_t q;
    int unsigned sh;
    sa = a;
    sb = b;
    sh = b % DataWidth;
    r.value = '0;
    r.st = StOk;
    case (op)
      OpInc:  r.value = a + 1'b1;
      OpDec:  r.value = a - 1'b1;
      OpLnot: r.value = word_t'(a == '0);
      OpBnot: r.value = ~a;
      OpNeg:  r.value = '0 - a;
      OpAdd:  r.value = a + b;
      OpSub:  r.value = a - b;
      OpMul:  r.value = a * b;
      OpDiv, OpMod: begin
        if (b == '0) begin
          r.st = StDivZero;
        end else begin
          // unsigned magnitudes, signs applied after
          ua = sa[DataWidth-1] ? ('0 - a) : a;
          ub = sb[DataWidth-1] ? ('0 - b) : b;
          if (op == OpDiv) begin
            q = ua / ub;
            r.value = (sa[DataWidth-1] != sb[DataWidth-1]) ? ('0 - q) : q;
          end else begin
            q = ua % ub;
            r.value = sa[DataWidth-1] ? ('0 - q) : q;
          end
        end
      end
      OpAnd:  r.value = a & b;
      OpOr:   r.value = a | b;
      OpXor:  r.value = a ^ b;
      OpGt:   r.value = word_t'(sa > sb);
      OpLt:   r.value = word_t'(sa < sb);
      OpShl:  r.value = a << sh;
      OpShr:  r.value = sa >>> sh;
      OpLand: r.value = word_t'((a != '0) && (b != '0));
      OpLor:  r.value = word_t'((a != '0) || (b != '0));
      OpEq:   r.value = word_t'(a == b);
      default: r.st = StUnsup;
    endcase
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // predict on input accept, compare on output accept
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(compute_alu(in_operation, in_left_operand,
                                               in_right_operand));
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected result value=%h status=%0d",
                     out_result_value, out_status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.value !== out_result_value || exp_r.st !== out_status) begin
            if (fail_count < 10)
              $display("ERROR: result %0d expected value=%h status=%0d got value=%h status=%0d",
                       result_count, exp_r.value, exp_r.st, out_result_value, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: verif/integer_operator_alu_tb.sv
// integer_operator_alu_tb: drives directed and random items into the integer ALU with
// random gaps and output stalls. Depends on ioa_pkg, the ALU and its checker.
`timescale 1ns / 1ps
module integer_operator_alu_tb;
  import ioa_pkg::*;

  localparam int RandomItems = 900;
  localparam int CycleLimit  = 200000;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  opcode_t in_operation = '0;
  word_t   in_left_operand = '0;
  word_t   in_right_operand = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  word_t   out_result_value;
  status_t out_status;
  int      fail_count;
  int      pending_count;
  int      result_count;
  int      cycle_count = 0;
  int      items_sent = 0;
  bit      no_idle = 1'b0;

  always #4 clk = ~clk;

  integer_operator_alu u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_left_operand(in_left_operand), .in_right_operand(in_right_operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_value(out_result_value), .out_status(out_status)
  );

  integer_operator_alu_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_left_operand(in_left_operand), .in_right_operand(in_right_operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_value(out_result_value), .out_status(out_status),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  // receiver stalls at random about 19 percent of the time, except in the no-idle stretch
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 19);
  end

  // run timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // random operand with extra weight on edge values
  function automatic word_t pick_operand();
    case ($urandom_range(7))
      0: return word_t'($urandom_range(3));
      1: return '1 - word_t'($urandom_range(2));
      2: return {1'b1, {(DataWidth-1){1'b0}}};
      3: return {1'b0, {(DataWidth-1){1'b1}}};
      4: return word_t'($urandom_range(40));
      default: return word_t'($urandom());
    endcase
  endfunction

  // present one item and hold it until accepted
  task automatic send_item(opcode_t op, word_t a, word_t b);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_left_operand <= a;
    in_right_operand <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    word_t min_w;
    word_t max_w;
    min_w = {1'b1, {(DataWidth-1){1'b0}}};
    max_w = ~min_w;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every opcode, extremes, divide by zero, min by minus one, unused codes
    for (int op = 0; op < 20; op++) send_item(opcode_t'(op), min_w, '1);
    send_item(OpDiv, max_w, '0);
    send_item(OpMod, min_w, '0);
    send_item(OpShr, min_w, 32'd63);
    send_item(OpShl, max_w, 32'd31);
    send_item(5'd20, max_w, max_w);
    send_item(5'd31, '0, '0);
    in_valid <= 1'b0;

    // sender holds off until the pipeline has drained
    while (pending_count != 0) @(posedge clk);

    for (int i = 0; i < RandomItems; i++) begin
      no_idle = (i >= 300 && i < 400);
      if ($urandom_range(99) < 93)
        send_item(opcode_t'($urandom_range(19)), pick_operand(), pick_operand());
      else
        send_item(opcode_t'($urandom_range(31, 20)), pick_operand(), pick_operand());
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);

    $display("Sent %0d items over all opcodes and unused codes; %0d results checked.",
             items_sent, result_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
